FILE: rtl/core/mer_pkg.sv
`default_nettype none
package mer_pkg;

	// Field and datapath widths
	localparam int RADIUS_BITS = 10;
	localparam int COORD_BITS  = 13;
	localparam int CX_W        = 11;
	localparam int CY_W        = 11;
	localparam int COLOR_W     = 4;
	localparam int PX_W        = 11;
	localparam int PY_W        = 12;
	localparam int TX_W        = PX_W + 1;
	localparam int TERM_W      = 32;
	localparam int DEC_W       = 48;
	localparam int SQ_W        = 2 * RADIUS_BITS;
	localparam int TSQ_W       = 2 * PY_W;
	localparam int MUL_W       = (SQ_W > TSQ_W) ? SQ_W : TSQ_W;
	localparam int PROD_W      = 2 * MUL_W;

	localparam int IN_FIELDS_W  = 2 * RADIUS_BITS;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * COORD_BITS + COLOR_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Configuration port
	localparam int ADDR_W = 4;
	localparam int APB_W  = 32;
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_CENTER_X    = 2'd0;
	localparam reg_idx_t REG_CENTER_Y    = 2'd1;
	localparam reg_idx_t REG_PIXEL_COLOR = 2'd2;

	localparam logic [CX_W-1:0]    CENTER_X_RST    = CX_W'(100);
	localparam logic [CY_W-1:0]    CENTER_Y_RST    = CY_W'(100);
	localparam logic [COLOR_W-1:0] PIXEL_COLOR_RST = COLOR_W'(4);

	// Microprogram
	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_IDLE = 5'd0;
	localparam step_t ST_CHK  = 5'd1;
	localparam step_t ST_E0   = 5'd2;
	localparam step_t ST_E1   = 5'd3;
	localparam step_t ST_R1_0 = 5'd4;
	localparam step_t ST_R1_1 = 5'd5;
	localparam step_t ST_R1_2 = 5'd6;
	localparam step_t ST_R1_3 = 5'd7;
	localparam step_t ST_R1_4 = 5'd8;
	localparam step_t ST_I0   = 5'd9;
	localparam step_t ST_I1   = 5'd10;
	localparam step_t ST_I2   = 5'd11;
	localparam step_t ST_I3   = 5'd12;
	localparam step_t ST_I4   = 5'd13;
	localparam step_t ST_I5   = 5'd14;
	localparam step_t ST_Q0   = 5'd15;
	localparam step_t ST_Q1   = 5'd16;
	localparam step_t ST_Q2   = 5'd17;
	localparam step_t ST_Q3   = 5'd18;
	localparam step_t ST_S0   = 5'd19;
	localparam step_t ST_S1   = 5'd20;
	localparam step_t ST_S2   = 5'd21;
	localparam step_t ST_S3   = 5'd22;
	localparam step_t ST_S4   = 5'd23;
	localparam step_t ST_FIN  = 5'd24;

	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_NO_INPUT,
		HOLD_EMIT_BUSY
	} hold_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_IS_START,
		C_NOT_ACTIVE,
		C_IS_FIN,
		C_IN_R2,
		C_NEG_Q,
		C_NOT_NEG_Q,
		C_SY_GT_SX
	} cond_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_RX_RX,
		MUL_RY_RY,
		MUL_RX2_RY,
		MUL_TX_TX,
		MUL_AY_AY,
		MUL_RY2_TMP,
		MUL_RX2_TMP,
		MUL_RX2_RY2
	} mul_t;

	typedef enum logic [1:0] {
		DEC_HOLD,
		DEC_LOAD,
		DEC_ADD,
		DEC_SUB
	} dec_op_t;

	typedef enum logic [2:0] {
		SRC_PROD,
		SRC_RX2,
		SRC_RY2,
		SRC_SX,
		SRC_SY
	} dec_src_t;

	typedef struct packed {
		hold_t    hold;
		cond_t    cond;
		step_t    target;
		mul_t     mul;
		dec_op_t  dec_op;
		dec_src_t dec_src;
		logic     dec_x4;
		logic     load_in;
		logic     snap;
		logic     neg_latch;
		logic     px_inc;
		logic     py_dec;
		logic     sx_add;
		logic     sy_sub;
		logic     sy_init;
		logic     tmp_ld;
		logic     rx2_ld;
		logic     ry2_ld;
		logic     begin_pt;
		logic     set_r2;
		logic     clr_active;
	} ucode_t;

	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t u;
		u = '0;
		unique case (s)
			ST_IDLE: begin
				u.hold = HOLD_NO_INPUT; u.load_in = 1'b1;
				u.cond = C_IS_START; u.target = ST_S0;
			end
			ST_CHK: begin
				u.cond = C_NOT_ACTIVE; u.target = ST_IDLE;
			end
			ST_E0: begin
				u.hold = HOLD_EMIT_BUSY; u.snap = 1'b1;
				u.cond = C_IS_FIN; u.target = ST_FIN;
			end
			ST_E1: begin
				u.cond = C_IN_R2; u.target = ST_Q0;
			end
			// region 1 step
			ST_R1_0: begin
				u.neg_latch = 1'b1; u.sx_add = 1'b1; u.px_inc = 1'b1;
				u.dec_op = DEC_ADD; u.dec_src = SRC_RY2; u.dec_x4 = 1'b1;
			end
			ST_R1_1: begin
				u.dec_op = DEC_ADD; u.dec_src = SRC_SX; u.dec_x4 = 1'b1;
				u.cond = C_NEG_Q; u.target = ST_R1_4;
			end
			ST_R1_2: begin
				u.py_dec = 1'b1; u.sy_sub = 1'b1;
			end
			ST_R1_3: begin
				u.dec_op = DEC_SUB; u.dec_src = SRC_SY; u.dec_x4 = 1'b1;
			end
			ST_R1_4: begin
				u.cond = C_SY_GT_SX; u.target = ST_IDLE;
			end
			// region 2 decision set-up
			ST_I0: begin
				u.mul = MUL_TX_TX;
			end
			ST_I1: begin
				u.tmp_ld = 1'b1; u.mul = MUL_AY_AY;
			end
			ST_I2: begin
				u.tmp_ld = 1'b1; u.mul = MUL_RY2_TMP;
			end
			ST_I3: begin
				u.dec_op = DEC_LOAD; u.dec_src = SRC_PROD; u.mul = MUL_RX2_TMP;
			end
			ST_I4: begin
				u.dec_op = DEC_ADD; u.dec_src = SRC_PROD; u.dec_x4 = 1'b1;
				u.mul = MUL_RX2_RY2;
			end
			ST_I5: begin
				u.dec_op = DEC_SUB; u.dec_src = SRC_PROD; u.dec_x4 = 1'b1;
				u.set_r2 = 1'b1; u.cond = C_ALWAYS; u.target = ST_IDLE;
			end
			// region 2 step
			ST_Q0: begin
				u.neg_latch = 1'b1; u.py_dec = 1'b1; u.sy_sub = 1'b1;
				u.dec_op = DEC_ADD; u.dec_src = SRC_RX2; u.dec_x4 = 1'b1;
			end
			ST_Q1: begin
				u.dec_op = DEC_SUB; u.dec_src = SRC_SY; u.dec_x4 = 1'b1;
				u.cond = C_NOT_NEG_Q; u.target = ST_IDLE;
			end
			ST_Q2: begin
				u.px_inc = 1'b1; u.sx_add = 1'b1;
			end
			ST_Q3: begin
				u.dec_op = DEC_ADD; u.dec_src = SRC_SX; u.dec_x4 = 1'b1;
				u.cond = C_ALWAYS; u.target = ST_IDLE;
			end
			// start of a new ellipse
			ST_S0: begin
				u.mul = MUL_RX_RX;
			end
			ST_S1: begin
				u.rx2_ld = 1'b1; u.mul = MUL_RY_RY;
			end
			ST_S2: begin
				u.ry2_ld = 1'b1; u.mul = MUL_RX2_RY;
				u.dec_op = DEC_LOAD; u.dec_src = SRC_RX2;
			end
			ST_S3: begin
				u.sy_init = 1'b1; u.begin_pt = 1'b1;
				u.dec_op = DEC_SUB; u.dec_src = SRC_PROD; u.dec_x4 = 1'b1;
			end
			ST_S4: begin
				u.dec_op = DEC_ADD; u.dec_src = SRC_RY2; u.dec_x4 = 1'b1;
				u.cond = C_ALWAYS; u.target = ST_E0;
			end
			ST_FIN: begin
				u.clr_active = 1'b1; u.cond = C_ALWAYS; u.target = ST_IDLE;
			end
			default: begin
				u.cond = C_ALWAYS; u.target = ST_IDLE;
			end
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/midpoint_ellipse_rasterizer_top.sv
`default_nettype none
// Midpoint ellipse rasterizer. A start item (s_axis_tuser = 0) carries the two semi-axes and
// places the point at (0, radius_y); each start or advance item (s_axis_tuser = 1) while an
// ellipse is in progress sends four pixels (+x,+y), (+x,-y), (-x,+y), (-x,-y), offset by the
// configured center and tagged with the configured color, then takes one midpoint step
// unless y = 0. m_axis_tlast marks the fourth pixel of an item, m_axis_tuser marks the
// point with y = 0 that ends the ellipse; advances after it give no pixels. A microprogram
// drives one shared multiplier and one 48-bit decision adder; new items are taken only
// while the sequencer is idle. Pixels leave one per cycle, while m_axis_tready allows,
// from an output register while the next step is computed; a point waits until the four
// pixels of the one before have entered the output register, so output stalls also hold
// the sequencer.
module midpoint_ellipse_rasterizer_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// s_axis_tdata: radius_x, radius_y
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [mer_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// s_axis_tuser: mode
	input  wire logic                           s_axis_tuser,
	// m_axis_tdata: pixel_x, pixel_y, color
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [mer_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                                m_axis_tlast,
	// m_axis_tuser: final_point
	output logic                                m_axis_tuser,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [mer_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [mer_pkg::APB_W-1:0]      pwdata,
	output logic [mer_pkg::APB_W-1:0]           prdata,
	output logic                                pready
);
	import mer_pkg::*;

	// configuration
	logic [CX_W-1:0]    center_x_q;
	logic [CY_W-1:0]    center_y_q;
	logic [COLOR_W-1:0] color_q;
	reg_idx_t           reg_idx;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
			color_q    <= PIXEL_COLOR_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_CENTER_X:    center_x_q <= pwdata[CX_W-1:0];
				REG_CENTER_Y:    center_y_q <= pwdata[CY_W-1:0];
				REG_PIXEL_COLOR: color_q    <= pwdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CENTER_X:    prdata = APB_W'(center_x_q);
			REG_CENTER_Y:    prdata = APB_W'(center_y_q);
			REG_PIXEL_COLOR: prdata = APB_W'(color_q);
			default:         prdata = '0;
		endcase
	end

	// sequencer
	step_t  step_q, step_d;
	ucode_t u;
	logic   hold, go, jump;

	logic [RADIUS_BITS-1:0] rin_x_q, rin_y_q;
	logic [SQ_W-1:0]        rx2_q, ry2_q;
	logic [TSQ_W-1:0]       tmp_q;
	logic [PROD_W-1:0]      prod_q, prod_d;
	logic [MUL_W-1:0]       mul_a, mul_b;
	logic [PX_W-1:0]        px_q;
	logic [PY_W-1:0]        py_q;
	logic [TERM_W-1:0]      sx_q, sy_q;
	logic [DEC_W-1:0]       dec_q, dec_b, dec_bs;
	logic                   neg_q, active_q, region_two_q;
	logic [TX_W-1:0]        tx;
	logic [PY_W-1:0]        ay;

	logic                   emit_busy_q;
	logic [1:0]             emit_cnt_q;
	logic [PX_W-1:0]        emit_px_q;
	logic [PY_W-1:0]        emit_py_q;
	logic                   emit_fin_q;

	assign u             = ucode_rom(step_q);
	assign s_axis_tready = (step_q == ST_IDLE);
	assign tx            = {px_q, 1'b1};
	assign ay            = (py_q == '0) ? PY_W'(1) : py_q - PY_W'(1);

	always_comb begin
		case (u.hold)
			HOLD_NO_INPUT:  hold = !s_axis_tvalid;
			HOLD_EMIT_BUSY: hold = emit_busy_q;
			default:        hold = 1'b0;
		endcase
		go = !hold;

		case (u.cond)
			C_ALWAYS:     jump = 1'b1;
			C_IS_START:   jump = !s_axis_tuser;
			C_NOT_ACTIVE: jump = !active_q;
			C_IS_FIN:     jump = (py_q == '0);
			C_IN_R2:      jump = region_two_q;
			C_NEG_Q:      jump = neg_q;
			C_NOT_NEG_Q:  jump = !neg_q;
			C_SY_GT_SX:   jump = (sy_q > sx_q);
			default:      jump = 1'b0;
		endcase

		if (hold)
			step_d = step_q;
		else if (jump)
			step_d = u.target;
		else
			step_d = step_q + step_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= ST_IDLE;
		else
			step_q <= step_d;
	end

	// shared multiplier, registered product
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (u.mul)
			MUL_RX_RX:   begin mul_a = MUL_W'(rin_x_q); mul_b = MUL_W'(rin_x_q); end
			MUL_RY_RY:   begin mul_a = MUL_W'(rin_y_q); mul_b = MUL_W'(rin_y_q); end
			MUL_RX2_RY:  begin mul_a = MUL_W'(rx2_q);   mul_b = MUL_W'(rin_y_q); end
			MUL_TX_TX:   begin mul_a = MUL_W'(tx);      mul_b = MUL_W'(tx);      end
			MUL_AY_AY:   begin mul_a = MUL_W'(ay);      mul_b = MUL_W'(ay);      end
			MUL_RY2_TMP: begin mul_a = MUL_W'(ry2_q);   mul_b = MUL_W'(tmp_q);   end
			MUL_RX2_TMP: begin mul_a = MUL_W'(rx2_q);   mul_b = MUL_W'(tmp_q);   end
			MUL_RX2_RY2: begin mul_a = MUL_W'(rx2_q);   mul_b = MUL_W'(ry2_q);   end
			default: ;
		endcase
		prod_d = mul_a * mul_b;
	end

	// decision adder operand
	always_comb begin
		case (u.dec_src)
			SRC_PROD: dec_b = DEC_W'(prod_q);
			SRC_RX2:  dec_b = DEC_W'(rx2_q);
			SRC_RY2:  dec_b = DEC_W'(ry2_q);
			SRC_SX:   dec_b = DEC_W'(sx_q);
			SRC_SY:   dec_b = DEC_W'(sy_q);
			default:  dec_b = '0;
		endcase
		dec_bs = u.dec_x4 ? (dec_b << 2) : dec_b;
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (u.load_in) begin
				rin_x_q <= s_axis_tdata[RADIUS_BITS-1:0];
				rin_y_q <= s_axis_tdata[2*RADIUS_BITS-1:RADIUS_BITS];
			end
			if (u.mul != MUL_NONE)
				prod_q <= prod_d;
			if (u.rx2_ld)
				rx2_q <= SQ_W'(prod_q);
			if (u.ry2_ld)
				ry2_q <= SQ_W'(prod_q);
			if (u.tmp_ld)
				tmp_q <= TSQ_W'(prod_q);
			if (u.neg_latch)
				neg_q <= dec_q[DEC_W-1];

			case (u.dec_op)
				DEC_LOAD: dec_q <= dec_bs;
				DEC_ADD:  dec_q <= dec_q + dec_bs;
				DEC_SUB:  dec_q <= dec_q - dec_bs;
				default: ;
			endcase

			if (u.begin_pt) begin
				px_q <= '0;
				py_q <= PY_W'(rin_y_q);
				sx_q <= '0;
			end
			if (u.px_inc)
				px_q <= px_q + PX_W'(1);
			if (u.py_dec)
				py_q <= py_q - PY_W'(1);
			if (u.sx_add)
				sx_q <= sx_q + (TERM_W'(ry2_q) << 1);
			if (u.sy_sub)
				sy_q <= sy_q - (TERM_W'(rx2_q) << 1);
			if (u.sy_init)
				sy_q <= TERM_W'(prod_q) << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			region_two_q <= 1'b0;
		end else if (go) begin
			if (u.begin_pt) begin
				active_q     <= 1'b1;
				region_two_q <= 1'b0;
			end
			if (u.set_r2)
				region_two_q <= 1'b1;
			if (u.clr_active)
				active_q <= 1'b0;
		end
	end

	// pixel emitter: snapshot of the point, four pixels into the output register
	logic                  out_ld;
	logic [COORD_BITS-1:0] x_term, y_term, cxw, cyw, pix_x, pix_y;
	logic [COORD_BITS-1:0] out_x_q, out_y_q;
	logic [COLOR_W-1:0]    out_color_q;
	logic                  out_last_q, out_fin_q, out_valid_q;

	assign out_ld = emit_busy_q && (!out_valid_q || m_axis_tready);
	assign x_term = COORD_BITS'(emit_px_q);
	assign y_term = COORD_BITS'(emit_py_q);
	assign cxw    = COORD_BITS'(center_x_q);
	assign cyw    = COORD_BITS'(center_y_q);
	assign pix_x  = emit_cnt_q[1] ? cxw - x_term : cxw + x_term;
	assign pix_y  = emit_cnt_q[0] ? cyw - y_term : cyw + y_term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_busy_q <= 1'b0;
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go && u.snap) begin
				emit_busy_q <= 1'b1;
				emit_cnt_q  <= '0;
			end else if (out_ld) begin
				emit_cnt_q <= emit_cnt_q + 2'd1;
				if (emit_cnt_q == 2'd3)
					emit_busy_q <= 1'b0;
			end
			if (out_ld)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && u.snap) begin
			emit_px_q  <= px_q;
			emit_py_q  <= py_q;
			emit_fin_q <= (py_q == '0);
		end
		if (out_ld) begin
			out_x_q     <= pix_x;
			out_y_q     <= pix_y;
			out_color_q <= color_q;
			out_last_q  <= (emit_cnt_q == 2'd3);
			out_fin_q   <= emit_fin_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_color_q, out_y_q, out_x_q});
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_fin_q;

endmodule
`default_nettype wire

FILE: rtl/core/mer_checker.sv
`default_nettype none
module mer_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_axis_tvalid,
	input wire logic                          s_axis_tready,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [mer_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                          m_axis_tlast,
	input wire logic                          m_axis_tuser
);
	import mer_pkg::*;

	// stalled pixel holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output pixel changed while stalled");

	// one item at a time: sequencer leaves idle after every transfer in
	a_in_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken on two consecutive cycles");

	// the four pixels of a point follow without gaps
	a_group_dense: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside a pixel group");

	// final flag is the same on all pixels of a point
	a_group_fin: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		m_axis_tuser == $past(m_axis_tuser))
		else $error("final flag changed inside a pixel group");

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker u_mer_checker (.*);
`default_nettype wire
